[rtl/core/gld_pkg.sv]
// Shared constants, codes and helpers for the grid local maximum detector.
// Used by grid_local_maximum_detect and gld_out_fifo; depends on nothing.
package gld_pkg;

    localparam int COUNT_WIDTH = 11;
    localparam int COUNT_MAX = 2047;
    localparam logic [COUNT_WIDTH-1:0] COUNT_RESET = 11'd3;

    localparam int CFG_INDEX_WIDTH = 2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ROW_COUNT = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_COLUMN_COUNT = 2'd1;

    localparam logic KIND_PEAK = 1'b0;
    localparam logic KIND_NONE = 1'b1;

    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_WIDTH = 2;
    localparam int OUT_LEVEL_WIDTH = 3;

    function automatic logic [COUNT_WIDTH-1:0] clamp_count(
        input logic [COUNT_WIDTH-1:0] value,
        input logic [COUNT_WIDTH-1:0] limit
    );
        logic [COUNT_WIDTH-1:0] result;
        if (value == '0) begin
            result = COUNT_WIDTH'(1);
        end else if (value > limit) begin
            result = limit;
        end else begin
            result = value;
        end
        return result;
    endfunction

endpackage

[rtl/core/grid_local_maximum_detect.sv]
// Top level of the four-neighbor local maximum detector over a raster grid.
// Depends on gld_pkg, gld_line_store and gld_out_fifo.
//
//  Channel  Direction  Handshake              Contents
//  s_       in         s_tvalid / s_tready    one grid pixel per word
//  m_       out        m_tvalid / m_tready    peak report or no-peak report
//  cfg_     in         cfg_valid / cfg_ready  row count (0), column count (1)
//
// One pixel is accepted per cycle while s_tready is high; the line store read issued at accept
// time returns in the next cycle, when the four compares run and the stores are written.
// A report is written into the result queue, from whose head it reaches m_tdata.
// Reset is synchronous on aresetn; both counts return to 3 and a new frame begins.
// s_tready drops only when the four-word result queue could overflow.
module grid_local_maximum_detect #(
    parameter int MAX_COLUMNS = 1024,
    parameter int MAX_ROWS = 1024,
    parameter int VALUE_WIDTH = 32
) (
    input  logic aclk,
    input  logic aresetn,

    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // pixel_value
    input  logic [((VALUE_WIDTH+7)/8)*8-1:0]     s_tdata,

    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // peak_value, peak_row, peak_column
    output logic [((VALUE_WIDTH+22+7)/8)*8-1:0]  m_tdata,
    // report_kind
    output logic                                 m_tuser,

    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [gld_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [gld_pkg::COUNT_WIDTH-1:0]      cfg_data
);

    localparam int CW = gld_pkg::COUNT_WIDTH;
    localparam int VW = VALUE_WIDTH;
    localparam int AW = $clog2(MAX_COLUMNS);
    localparam int PW = (AW > CW) ? AW : CW;
    localparam int OUT_W = ((VW + 2 * CW + 7) / 8) * 8;
    localparam int FW = 1 + VW + 2 * CW;
    localparam int ROW_LIM = (MAX_ROWS < gld_pkg::COUNT_MAX) ? MAX_ROWS : gld_pkg::COUNT_MAX;
    localparam int COL_LIM =
        (MAX_COLUMNS < gld_pkg::COUNT_MAX) ? MAX_COLUMNS : gld_pkg::COUNT_MAX;

    logic [CW-1:0] rows_reg, cols_reg;
    logic [CW-1:0] row_pos_reg, row_pos_next;
    logic [CW-1:0] col_pos_reg, col_pos_next;
    logic          cfg_write, accept;
    logic          col_last, row_last, eval0;
    logic [PW-1:0] col_ext, col_ext_next;

    logic          s1_valid_reg, s1_eval_reg, s1_last_reg;
    logic [VW-1:0] s1_below_reg;
    logic [CW-1:0] s1_row_reg, s1_col_reg;
    logic [AW-1:0] s1_addr_reg;
    logic [VW-1:0] left_reg;
    logic          peak_seen_reg;

    logic [VW-1:0] up_data, mid_data, right_data;
    logic          peak, none, push;
    logic [FW-1:0] push_data, head_data;
    logic [gld_pkg::OUT_LEVEL_WIDTH-1:0] level;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready &&
                       (cfg_index == gld_pkg::REG_ROW_COUNT ||
                        cfg_index == gld_pkg::REG_COLUMN_COUNT);

    assign s_tready = (level + gld_pkg::OUT_LEVEL_WIDTH'(s1_valid_reg)) <
                      gld_pkg::OUT_LEVEL_WIDTH'(gld_pkg::OUT_DEPTH);
    assign accept = s_tvalid && s_tready;

    assign col_last = (col_pos_reg == cols_reg - 1'b1);
    assign row_last = (row_pos_reg == rows_reg - 1'b1);
    assign eval0 = (row_pos_reg >= CW'(2)) && (col_pos_reg != '0) && !col_last;
    assign col_ext = PW'(col_pos_reg);
    assign col_ext_next = col_ext + PW'(1);

    always_comb begin
        row_pos_next = row_pos_reg;
        col_pos_next = col_pos_reg;
        if (cfg_write) begin
            row_pos_next = '0;
            col_pos_next = '0;
        end else if (accept) begin
            priority if (!col_last) begin
                col_pos_next = col_pos_reg + 1'b1;
            end else if (!row_last) begin
                col_pos_next = '0;
                row_pos_next = row_pos_reg + 1'b1;
            end else begin
                col_pos_next = '0;
                row_pos_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg <= gld_pkg::COUNT_RESET;
            cols_reg <= gld_pkg::COUNT_RESET;
            row_pos_reg <= '0;
            col_pos_reg <= '0;
            s1_valid_reg <= 1'b0;
            peak_seen_reg <= 1'b0;
            left_reg <= '0;
        end else begin
            if (cfg_write) begin
                if (cfg_index == gld_pkg::REG_ROW_COUNT) begin
                    rows_reg <= gld_pkg::clamp_count(cfg_data, CW'(ROW_LIM));
                end else begin
                    cols_reg <= gld_pkg::clamp_count(cfg_data, CW'(COL_LIM));
                end
            end
            row_pos_reg <= row_pos_next;
            col_pos_reg <= col_pos_next;
            s1_valid_reg <= accept;
            if (s1_valid_reg) begin
                left_reg <= mid_data;
            end
            if (cfg_write) begin
                peak_seen_reg <= 1'b0;
            end else if (s1_valid_reg) begin
                if (s1_last_reg) begin
                    peak_seen_reg <= 1'b0;
                end else if (peak) begin
                    peak_seen_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_eval_reg <= eval0;
            s1_last_reg <= col_last && row_last;
            s1_below_reg <= s_tdata[VW-1:0];
            s1_row_reg <= row_pos_reg;
            s1_col_reg <= col_pos_reg;
            s1_addr_reg <= col_ext[AW-1:0];
        end
    end

    gld_line_store #(
        .DEPTH (MAX_COLUMNS),
        .AW    (AW),
        .VW    (VW)
    ) u_line_store (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .rd_en        (accept),
        .rd_addr      (col_ext[AW-1:0]),
        .rd_addr_next (col_ext_next[AW-1:0]),
        .wr_en        (s1_valid_reg),
        .wr_addr      (s1_addr_reg),
        .wr_upper     (mid_data),
        .wr_middle    (s1_below_reg),
        .up_data      (up_data),
        .mid_data     (mid_data),
        .right_data   (right_data)
    );

    assign peak = s1_eval_reg &&
                  ($signed(mid_data) > $signed(up_data)) &&
                  ($signed(mid_data) > $signed(s1_below_reg)) &&
                  ($signed(mid_data) > $signed(left_reg)) &&
                  ($signed(mid_data) > $signed(right_data));
    assign none = s1_last_reg && !peak_seen_reg && !peak;
    assign push = s1_valid_reg && (peak || none);

    always_comb begin
        if (peak) begin
            push_data = {s1_col_reg + 1'b1, s1_row_reg, mid_data, gld_pkg::KIND_PEAK};
        end else begin
            push_data = {cols_reg, rows_reg, VW'(0), gld_pkg::KIND_NONE};
        end
    end

    gld_out_fifo #(
        .W (FW)
    ) u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (head_data),
        .level     (level)
    );

    assign m_tuser = head_data[0];
    assign m_tdata = OUT_W'(head_data[FW-1:1]);

endmodule

[rtl/core/gld_line_store.sv]
// Upper and middle line stores with registered synchronous reads.
// Forwards a write that lands on the same edge as a read of that entry.
// Depends on no package.
module gld_line_store #(
    parameter int DEPTH = 1024,
    parameter int AW = 10,
    parameter int VW = 32
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    input  logic [AW-1:0] rd_addr_next,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [VW-1:0] wr_upper,
    input  logic [VW-1:0] wr_middle,
    output logic [VW-1:0] up_data,
    output logic [VW-1:0] mid_data,
    output logic [VW-1:0] right_data
);

    logic [VW-1:0] upper_mem [DEPTH];
    logic [VW-1:0] middle_mem [DEPTH];

    logic [VW-1:0] up_q_reg;
    logic [VW-1:0] mid_q_reg;
    logic [VW-1:0] right_q_reg;
    logic [VW-1:0] fwd_upper_reg;
    logic [VW-1:0] fwd_middle_reg;
    logic          hit_cur_reg;
    logic          hit_next_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            upper_mem[wr_addr] <= wr_upper;
            middle_mem[wr_addr] <= wr_middle;
        end
        if (rd_en) begin
            up_q_reg <= upper_mem[rd_addr];
            mid_q_reg <= middle_mem[rd_addr];
            right_q_reg <= middle_mem[rd_addr_next];
            fwd_upper_reg <= wr_upper;
            fwd_middle_reg <= wr_middle;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_cur_reg <= 1'b0;
            hit_next_reg <= 1'b0;
        end else if (rd_en) begin
            hit_cur_reg <= wr_en && (wr_addr == rd_addr);
            hit_next_reg <= wr_en && (wr_addr == rd_addr_next);
        end
    end

    assign up_data = hit_cur_reg ? fwd_upper_reg : up_q_reg;
    assign mid_data = hit_cur_reg ? fwd_middle_reg : mid_q_reg;
    assign right_data = hit_next_reg ? fwd_middle_reg : right_q_reg;

endmodule

[rtl/core/gld_out_fifo.sv]
// Small result queue that decouples the compare stage from the output side.
// Depends on gld_pkg for its depth and pointer widths.
module gld_out_fifo #(
    parameter int W = 55
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                push,
    input  logic [W-1:0]                        push_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [W-1:0]                        out_data,
    output logic [gld_pkg::OUT_LEVEL_WIDTH-1:0] level
);

    logic [W-1:0] entry_reg [gld_pkg::OUT_DEPTH];
    logic [gld_pkg::OUT_PTR_WIDTH-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [gld_pkg::OUT_PTR_WIDTH-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [gld_pkg::OUT_LEVEL_WIDTH-1:0] count_reg, count_next;
    logic pop;

    assign out_valid = (count_reg != '0);
    assign out_data = entry_reg[rd_ptr_reg];
    assign level = count_reg;
    assign pop = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

endmodule
